// ----- src/rc4krd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rc4krd_pkg;

    // permutation store geometry
    localparam int PERM_W     = 8;
    localparam int PERM_DEPTH = 256;

    // hash arithmetic
    localparam int          HASH_W   = 30;
    localparam logic [29:0] HASH_MUL = 30'd425481007;
    localparam logic [29:0] HASH_MOD = 30'd1000000007;

    // operand width of the shared reduction unit
    localparam int RED_W = 64;

    typedef logic [PERM_W-1:0] t_byte;
    typedef logic [HASH_W-1:0] t_hash;

    // request opcodes
    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_REPORT = 1'b1
    } t_op;

    // keystream byte placement within the decode mask
    localparam logic [4:0] KS_SHIFT0 = 5'd0;
    localparam logic [4:0] KS_SHIFT1 = 5'd8;
    localparam logic [4:0] KS_SHIFT2 = 5'd16;
    localparam logic [4:0] KS_SHIFT3 = 5'd22;

    function automatic logic [4:0] ks_shift(input logic [1:0] idx);
        logic [4:0] s;
        unique case (idx)
            2'd0:    s = KS_SHIFT0;
            2'd1:    s = KS_SHIFT1;
            2'd2:    s = KS_SHIFT2;
            default: s = KS_SHIFT3;
        endcase
        return s;
    endfunction

    // request to the reduction unit
    typedef struct packed {
        logic             start;
        logic [RED_W-1:0] operand;
    } t_red_ctl;

    // reduction unit status
    typedef struct packed {
        logic  busy;
        logic  done;
        t_hash rem;
    } t_red_sts;

endpackage
`default_nettype wire

// ----- src/rc4krd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rc4krd_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [63:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

// ----- src/rc4krd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rc4krd_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] decoded;
    logic        [29:0] hash_now;

    modport source (output valid, output decoded, output hash_now, input ready);
    modport sink (input valid, input decoded, input hash_now, output ready);
endinterface
`default_nettype wire

// ----- src/rc4_keystream_reseeding_decoder_top.sv -----
// RC4 keystream decoder with answer-driven reseeding.
// Request channel i_req carries opcode and value; response channel o_rsp
// carries decoded and hash_now, one response per request, in order.
// After reset the permutation is filled with the identity and the key
// schedule runs with the zero key, each entry read, swapped and written back
// through the single read port of the permutation memory; i_req.ready rises
// once the key schedule has finished.
// Decode request: four keystream bytes, each through states PRDA, PGOTA,
// PGOTB, PWRA, PRDT and PGOTT; the response is registered in ST_DEMIT.
// Report request: one multiply, then two passes of the shared
// modular reduction unit (16-bit digits, reciprocal estimate); a response
// is registered in ST_REMIT, then the reseed (identity fill and key
// schedule) runs before the next request is taken.
// Only one request is in flight; ready is low while it is processed.
// The response sits in an output register; a stalled receiver does not
// block the next request until that one's response must be written.
// Reset is synchronous, active low, and clears hash, count and indices.
`timescale 1ns / 1ps
`default_nettype none
module rc4_keystream_reseeding_decoder_top
    import rc4krd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rc4krd_in_if.sink    i_req,
    rc4krd_out_if.source o_rsp
);

    typedef enum logic [4:0] {
        ST_CLR,
        ST_KRDA,
        ST_KGOTA,
        ST_KGOTB,
        ST_KWRA,
        ST_IDLE,
        ST_PRDA,
        ST_PGOTA,
        ST_PGOTB,
        ST_PWRA,
        ST_PRDT,
        ST_PGOTT,
        ST_DEMIT,
        ST_HMUL,
        ST_HSTART,
        ST_HWAIT,
        ST_VSTART,
        ST_VWAIT,
        ST_HSUM,
        ST_REMIT
    } t_state;

    localparam int   AW       = $clog2(PERM_DEPTH);
    localparam t_byte LAST_IX = t_byte'(PERM_DEPTH - 1);

    t_state             r_state;
    t_byte              r_n;
    t_byte              r_acc;
    t_byte              r_a;
    t_byte              r_b;
    t_byte              r_i;
    t_byte              r_j;
    logic [1:0]         r_bc;
    logic [29:0]        r_ks;
    logic signed [63:0] r_val;
    t_hash              r_hash;
    logic [31:0]        r_count;
    logic [59:0]        r_prod;
    t_hash              r_hmul;
    t_hash              r_vres;
    logic               r_ov;
    logic signed [63:0] r_dec;
    t_hash              r_hn;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_byte         ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_byte         ram_rdata;

    t_red_ctl red_ctl;
    t_red_sts red_sts;

    logic          accept;
    logic          out_free;
    logic          rsp_load;
    logic [63:0]   key_word;
    t_byte         n_key;
    t_byte         n_acc;
    t_byte         n_j;
    logic [63:0]   n_mag;
    t_hash         n_vres;
    logic [HASH_W:0] n_sum;
    t_hash         n_hash;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;
    assign rsp_load = ((r_state == ST_DEMIT) || (r_state == ST_REMIT)) && out_free;

    // key bytes: hash then count, little-endian
    assign key_word = {r_count, 2'b00, r_hash};
    assign n_key    = key_word[{r_n[2:0], 3'b000} +: 8];
    assign n_acc    = r_acc + ram_rdata + n_key;
    assign n_j      = r_j + ram_rdata;

    // hash folding arithmetic
    assign n_mag  = r_val[63] ? (64'd0 - $unsigned(r_val)) : $unsigned(r_val);
    assign n_vres = (r_val[63] && (red_sts.rem != '0)) ? (HASH_MOD - red_sts.rem)
                                                       : red_sts.rem;
    assign n_sum  = {1'b0, r_hmul} + {1'b0, r_vres};
    assign n_hash = (n_sum >= {1'b0, HASH_MOD}) ? HASH_W'(n_sum - {1'b0, HASH_MOD})
                                                : n_sum[HASH_W-1:0];

    // permutation memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_n;
        ram_wdata = r_n;
        ram_raddr = r_n;
        unique case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
            end
            ST_KGOTA: begin
                ram_raddr = n_acc;
            end
            ST_KGOTB: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_KWRA: begin
                ram_we    = 1'b1;
                ram_waddr = r_acc;
                ram_wdata = r_a;
            end
            ST_PRDA: begin
                ram_raddr = r_i + 1'b1;
            end
            ST_PGOTA: begin
                ram_raddr = n_j;
            end
            ST_PGOTB: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
            end
            ST_PWRA: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_a;
            end
            ST_PRDT: begin
                ram_raddr = r_a + r_b;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // reduction requests
    always_comb begin
        red_ctl.start   = (r_state == ST_HSTART) || (r_state == ST_VSTART);
        red_ctl.operand = (r_state == ST_VSTART) ? n_mag : {4'b0000, r_prod};
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_hash  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output register: load on a new response, clear once taken
            if (rsp_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_n <= r_n + 1'b1;
                    if (r_n == LAST_IX) begin
                        r_acc   <= '0;
                        r_state <= ST_KRDA;
                    end
                end
                ST_KRDA: begin
                    r_state <= ST_KGOTA;
                end
                ST_KGOTA: begin
                    r_a     <= ram_rdata;
                    r_acc   <= n_acc;
                    r_state <= ST_KGOTB;
                end
                ST_KGOTB: begin
                    r_state <= ST_KWRA;
                end
                ST_KWRA: begin
                    r_n <= r_n + 1'b1;
                    if (r_n == LAST_IX) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_KRDA;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_val <= i_req.value;
                        r_ks  <= '0;
                        r_bc  <= '0;
                        if (i_req.opcode == OP_REPORT) begin
                            r_state <= ST_HMUL;
                        end else begin
                            r_state <= ST_PRDA;
                        end
                    end
                end
                ST_PRDA: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= ST_PGOTA;
                end
                ST_PGOTA: begin
                    r_a     <= ram_rdata;
                    r_j     <= n_j;
                    r_state <= ST_PGOTB;
                end
                ST_PGOTB: begin
                    r_b     <= ram_rdata;
                    r_state <= ST_PWRA;
                end
                ST_PWRA: begin
                    r_state <= ST_PRDT;
                end
                ST_PRDT: begin
                    r_state <= ST_PGOTT;
                end
                ST_PGOTT: begin
                    r_ks <= r_ks ^ (30'(ram_rdata) << ks_shift(r_bc));
                    r_bc <= r_bc + 1'b1;
                    if (r_bc == 2'd3) begin
                        r_state <= ST_DEMIT;
                    end else begin
                        r_state <= ST_PRDA;
                    end
                end
                ST_DEMIT: begin
                    if (out_free) begin
                        r_dec   <= r_val ^ {34'd0, r_ks};
                        r_hn    <= r_hash;
                        r_state <= ST_IDLE;
                    end
                end
                ST_HMUL: begin
                    r_prod  <= r_hash * HASH_MUL;
                    r_state <= ST_HSTART;
                end
                ST_HSTART: begin
                    r_state <= ST_HWAIT;
                end
                ST_HWAIT: begin
                    if (red_sts.done) begin
                        r_hmul  <= red_sts.rem;
                        r_state <= ST_VSTART;
                    end
                end
                ST_VSTART: begin
                    r_state <= ST_VWAIT;
                end
                ST_VWAIT: begin
                    if (red_sts.done) begin
                        r_vres  <= n_vres;
                        r_state <= ST_HSUM;
                    end
                end
                ST_HSUM: begin
                    r_hash  <= n_hash;
                    r_count <= r_count + 1'b1;
                    r_state <= ST_REMIT;
                end
                ST_REMIT: begin
                    if (out_free) begin
                        r_dec   <= r_val;
                        r_hn    <= r_hash;
                        r_n     <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_CLR;
                    end
                end
                default: begin
                    r_state <= ST_CLR;
                end
            endcase
        end
    end

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_rsp.valid    = r_ov;
    assign o_rsp.decoded  = r_dec;
    assign o_rsp.hash_now = r_hn;

    rc4krd_ram #(
        .WIDTH (PERM_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rc4krd_modred u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (red_ctl),
        .o_sts   (red_sts)
    );

    // hash register always holds a residue
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hash < HASH_MOD)
        else $error("hash out of range");

    // permutation is never written while requests are taken
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !ram_we)
        else $error("permutation written while idle");

    // the reduction unit is quiet whenever a request can be taken
    a_idle_red_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !red_sts.busy)
        else $error("reduction busy while idle");

    // an accepted request closes the channel on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while one is in flight");

endmodule
`default_nettype wire

// ----- src/rc4krd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rc4krd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read of the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- src/rc4krd_modred.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rc4krd_modred
    import rc4krd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_red_ctl i_ctl,
    output t_red_sts o_sts
);

    // operand is folded in 16-bit digits, most significant first
    localparam int               DIG_W = 16;
    localparam int               N_DIG = RED_W / DIG_W;
    localparam int               CNT_W = $clog2(N_DIG);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(N_DIG - 1);

    // quotient estimate from the upper bits of the partial value
    localparam int T_W    = HASH_W + DIG_W;
    localparam int EST_SH = 28;
    localparam int HI_W   = T_W - EST_SH;
    localparam int RCP_SH = 32;
    localparam int RCP_W  = 31;
    localparam int PROD_W = HI_W + RCP_W;
    localparam logic [63:0] RCP_FULL = (64'd1 << (EST_SH + RCP_SH)) / 64'(HASH_MOD);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    logic             r_busy;
    logic             r_done;
    logic             r_fix;
    logic [CNT_W-1:0] r_cnt;
    logic [RED_W-1:0] r_sh;
    t_hash            r_rem;
    logic [HI_W-1:0]  r_q;

    logic [T_W-1:0]    n_t;
    logic [PROD_W-1:0] n_prod;
    logic [HI_W-1:0]   n_q;
    logic [T_W-1:0]    n_diff;
    logic [HASH_W:0]   n_part;
    t_hash             n_rem;

    // estimate never exceeds the true quotient and falls short by at most one,
    // so one compare and subtract finishes the digit
    always_comb begin
        n_t    = {r_rem, r_sh[RED_W-1 -: DIG_W]};
        n_prod = PROD_W'(n_t[T_W-1:EST_SH]) * PROD_W'(RCP);
        n_q    = HI_W'(n_prod >> RCP_SH);
        n_diff = n_t - (T_W'(r_q) * T_W'(HASH_MOD));
        n_part = n_diff[HASH_W:0];
        if (n_part >= {1'b0, HASH_MOD}) begin
            n_rem = HASH_W'(n_part - {1'b0, HASH_MOD});
        end else begin
            n_rem = n_part[HASH_W-1:0];
        end
    end

    // per digit: an estimate step, then a subtract and correct step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_fix && (r_cnt == LAST);
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
                r_cnt  <= '0;
                r_sh   <= i_ctl.operand;
                r_rem  <= '0;
            end else if (r_busy && !r_fix) begin
                r_q   <= n_q;
                r_fix <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sh  <= r_sh << DIG_W;
                r_cnt <= r_cnt + 1'b1;
                r_fix <= 1'b0;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

    // remainder stays a true residue
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < HASH_MOD))
        else $error("residue out of range");

    // a new pass is never requested while one runs
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start)
        else $error("reduction restarted while busy");

    // completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import rc4krd_pkg::*;

    typedef struct {
        t_op         op;
        logic [63:0] value;
        bit          hold;
    } t_cmd;

    typedef struct {
        logic [63:0] decoded;
        logic [29:0] hash_now;
    } t_rsp_word;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;
    localparam longint unsigned MOD64 = 64'(HASH_MOD);
    localparam longint unsigned MUL64 = 64'(HASH_MUL);
    localparam logic [63:0] W_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;

    logic i_clk;
    logic i_rst_n;

    rc4krd_in_if  req_if ();
    rc4krd_out_if rsp_if ();

    rc4_keystream_reseeding_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor state: permutation, indices, hash and answer count
    logic [7:0]  sbox [256];
    logic [7:0]  ks_i;
    logic [7:0]  ks_j;
    logic [29:0] hash_acc;
    logic [31:0] answer_cnt;

    t_cmd      cmd_q [$];
    t_rsp_word decoded_q [$];
    t_rsp_word head_word;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned error_cnt;
    int unsigned idle_cycles;

    // key schedule with key = hash bytes then count bytes, little-endian
    function automatic void rekey();
        logic [7:0]  key [8];
        logic [7:0]  acc;
        logic [7:0]  t;
        logic [31:0] h32;
        h32 = {2'b00, hash_acc};
        for (int n = 0; n < 4; n++) begin
            key[n]     = 8'(h32 >> (8 * n));
            key[n + 4] = 8'(answer_cnt >> (8 * n));
        end
        for (int n = 0; n < 256; n++) sbox[n] = 8'(n);
        ks_i = '0;
        ks_j = '0;
        acc  = '0;
        for (int n = 0; n < 256; n++) begin
            acc = acc + sbox[n] + key[n % 8];
            t = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = t;
        end
    endfunction

    function automatic logic [7:0] next_ks_byte();
        logic [7:0] t;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        t = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = t;
        return sbox[8'(sbox[ks_i] + sbox[ks_j])];
    endfunction

    // nonnegative residue of a signed 64-bit answer
    function automatic logic [29:0] true_residue(logic [63:0] v);
        longint unsigned mag;
        longint unsigned r;
        if (!v[63]) return 30'(v % MOD64);
        mag = 64'd0 - v;
        r = mag % MOD64;
        return (r == 0) ? 30'd0 : 30'(MOD64 - r);
    endfunction

    // response for one request, advancing the predictor state
    function automatic t_rsp_word rc4_apply(t_op op, logic [63:0] v);
        t_rsp_word       w;
        logic [63:0]     mask;
        longint unsigned h;
        if (op == OP_DECODE) begin
            mask = 64'(next_ks_byte());
            mask = mask ^ (64'(next_ks_byte()) << 8);
            mask = mask ^ (64'(next_ks_byte()) << 16);
            mask = mask ^ (64'(next_ks_byte()) << 22);
            w.decoded = v ^ mask;
        end else begin
            h = (64'(hash_acc) * MUL64) % MOD64;
            h = (h + 64'(true_residue(v))) % MOD64;
            answer_cnt = answer_cnt + 32'd1;
            hash_acc = 30'(h);
            rekey();
            w.decoded = v;
        end
        w.hash_now = hash_acc;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_cnt++;
    endtask

    task automatic queue_cmd(input t_op op, input logic [63:0] v, input bit hold = 1'b0);
        t_cmd c;
        c.op = op;
        c.value = v;
        c.hold = hold;
        cmd_q = {cmd_q, c};
    endtask

    // mix of full-range words, small signed values, near multiples of the modulus and extremes
    function automatic logic [63:0] rand_word();
        longint w;
        case ($urandom_range(7))
            0: w = longint'($urandom_range(2000)) - 1000;
            1: begin
                w = longint'(64'($urandom) * MOD64) + longint'($urandom_range(4)) - 2;
                if ($urandom_range(1)) w = -w;
            end
            2: begin
                case ($urandom_range(5))
                    0: w = longint'(W_MAX);
                    1: w = longint'(W_MIN);
                    2: w = 0;
                    3: w = -1;
                    4: w = longint'(MOD64);
                    default: w = -longint'(MOD64);
                endcase
            end
            default: w = longint'({$urandom, $urandom});
        endcase
        return 64'(w);
    endfunction

    // runs of decodes of varying length, each closed by a report while the count lasts
    task automatic queue_random(input int count);
        int left;
        int run;
        left = count;
        while (left > 0) begin
            run = $urandom_range(1) ? $urandom_range(3) : $urandom_range(90, 30);
            for (int n = 0; n < run && left > 0; n++) begin
                queue_cmd(OP_DECODE, rand_word(), left == count);
                left--;
            end
            if (left > 0) begin
                queue_cmd(OP_REPORT, rand_word(), left == count);
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || req_if.valid || decoded_q.size() != 0)
            @(negedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid  <= 1'b0;
            req_if.opcode <= OP_DECODE;
            req_if.value  <= '0;
        end else begin
            if (req_if.valid && req_if.ready)
                decoded_q = {decoded_q, rc4_apply(t_op'(req_if.opcode), req_if.value)};
            if (!req_if.valid || req_if.ready) begin
                if (cmd_q.size() != 0 && !(cmd_q[0].hold && decoded_q.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    req_if.valid  <= 1'b1;
                    req_if.opcode <= cmd_q[0].op;
                    req_if.value  <= cmd_q[0].value;
                    void'(cmd_q.pop_front());
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("response with no request pending");
                end else begin
                    head_word = decoded_q.pop_front();
                    if (rsp_if.decoded !== head_word.decoded)
                        report_mismatch($sformatf("decoded %h, want %h",
                            rsp_if.decoded, head_word.decoded));
                    if (rsp_if.hash_now !== head_word.hash_now)
                        report_mismatch($sformatf("hash_now %0d, want %0d",
                            rsp_if.hash_now, head_word.hash_now));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any request or response moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and phase control
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.opcode  = OP_DECODE;
        req_if.value   = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_cnt      = 0;
        idle_cycles    = 0;
        hash_acc       = '0;
        answer_cnt     = '0;
        rekey();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: word extremes, negative answers, multiples of the modulus
        queue_cmd(OP_DECODE, 64'd0);
        queue_cmd(OP_DECODE, '1);
        queue_cmd(OP_DECODE, W_MAX);
        queue_cmd(OP_DECODE, W_MIN);
        queue_cmd(OP_DECODE, 64'h5555_5555_5555_5555);
        queue_cmd(OP_DECODE, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_cmd(OP_REPORT, 64'd0, 1'b1);
        queue_cmd(OP_DECODE, 64'd0);
        queue_cmd(OP_REPORT, '1);
        queue_cmd(OP_DECODE, '1);
        queue_cmd(OP_REPORT, W_MAX);
        queue_cmd(OP_REPORT, W_MIN);
        queue_cmd(OP_DECODE, W_MIN);
        queue_cmd(OP_REPORT, MOD64);
        queue_cmd(OP_REPORT, 64'd0 - MOD64);
        queue_cmd(OP_REPORT, MOD64 - 64'd1);
        queue_cmd(OP_REPORT, 64'd0 - (MOD64 - 64'd1));
        queue_cmd(OP_REPORT, 64'd0 - (MOD64 + 64'd1));
        queue_cmd(OP_DECODE, 64'h0123_4567_89AB_CDEF);
        wait_drained();

        // random phases under different idling
        queue_random(200);
        wait_drained();

        send_idle_pct = 87;
        queue_random(200);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        queue_random(200);
        wait_drained();

        send_idle_pct  = 38;
        recv_stall_pct = 38;
        queue_random(200);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", decoded_q.size()));
        if (error_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
